// File: hdl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants of the tile triangle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none
package trz_pkg;

	// Tile geometry and depth store.
	localparam int TILE_SIZE   = 8;
	localparam int STORE_DEPTH = TILE_SIZE * TILE_SIZE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam logic [23:0] FAR_DEPTH = 24'hFFFFFF;

	// Operand width of the dividers; their remainder path is one bit wider.
	localparam int DIV_W = 42;

	// Configuration register indexes.
	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_SCREEN_W = 2'd2;
	localparam logic [1:0] REG_SCREEN_H = 2'd3;

	// Register settings seen by the core.
	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [12:0] screen_w;
		logic [12:0] screen_h;
	} cfg_t;

	// Depth store access from the core.
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [23:0]       wr_data;
	} mem_req_t;

	// One fragment.
	typedef struct packed {
		logic        last;
		logic [15:0] bary_one;
		logic [15:0] bary_zero;
		logic [23:0] frag_depth;
		logic [11:0] pixel_y;
		logic [11:0] pixel_x;
	} frag_t;

endpackage
`default_nettype wire

// File: hdl/trz_depth_mem.sv
// ----------------------------------------------------------------------------
// trz_depth_mem
// Tile depth store: one synchronous RAM with per-entry valid bits so that a
// clear takes effect at once; an entry that is not valid reads as far.
// ----------------------------------------------------------------------------
`default_nettype none
module trz_depth_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire trz_pkg::mem_req_t req,
	output logic [23:0]            rd_data
);

	logic [23:0] mem [trz_pkg::STORE_DEPTH];
	logic [trz_pkg::STORE_DEPTH-1:0] valid_q;

	// Storage array, written and read in one clocked block.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= valid_q[req.addr] ? mem[req.addr] : trz_pkg::FAR_DEPTH;
		end
	end

	// Valid bits: cleared on reset and on an origin write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/trz_div.sv
// ----------------------------------------------------------------------------
// trz_div
// Restoring divider for unit fractions: quo = floor(num * 65536 / den) with
// num <= den, one quotient bit per cycle into a 17-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module trz_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [trz_pkg::DIV_W-1:0] num,
	input  wire logic [trz_pkg::DIV_W-1:0] den,
	output logic                           done,
	output logic [16:0]                    quo
);

	logic [trz_pkg::DIV_W:0]   rem_q;
	logic [trz_pkg::DIV_W-1:0] den_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic [trz_pkg::DIV_W:0]   rem_cur;
	logic                      ge;

	// Shift the partial remainder except on the first step.
	assign rem_cur = (cnt_q == 5'd0) ? rem_q : {rem_q[trz_pkg::DIV_W-1:0], 1'b0};
	assign ge      = rem_cur >= {1'b0, den_q};

	// Operands and partial results.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_cur - {1'b0, den_q} : rem_cur;
			quo   <= {quo[15:0], ge};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/trz_core.sv
// ----------------------------------------------------------------------------
// trz_core
// Triangle setup, pixel scan sequencer with edge tests, perspective weights,
// depth read-compare-write and the fragment output register.
// ----------------------------------------------------------------------------
`default_nettype none
module trz_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire trz_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [251:0]      in_data,
	output trz_pkg::mem_req_t      mem_req,
	input  wire logic [23:0]       mem_rd_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output trz_pkg::frag_t         out_frag
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SET1  = 4'd1;
	localparam logic [3:0] ST_SET2  = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_EDGE  = 4'd4;
	localparam logic [3:0] ST_DIV1  = 4'd5;
	localparam logic [3:0] ST_Q     = 4'd6;
	localparam logic [3:0] ST_QS    = 4'd7;
	localparam logic [3:0] ST_DIV2  = 4'd8;
	localparam logic [3:0] ST_DMUL  = 4'd9;
	localparam logic [3:0] ST_DEP   = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0] state_q;

	// Triangle registers.
	logic signed [17:0] vx0_q, vy0_q, vx1_q, vy1_q, vx2_q, vy2_q;
	logic [23:0] z0_q, z1_q, z2_q, w0_q, w1_q, w2_q;
	logic signed [41:0] area_q, am0_q, am1_q;
	logic signed [14:0] bx0_q, bx1_q, by0_q, by1_q, x_q, y_q;

	// Per-pixel registers.
	logic signed [41:0] m0_q, m1_q, m2_q, m3_q;
	logic [16:0] s0_q, s1_q, p0_q, p1_q;
	logic [40:0] q0_q, q1_q, q2_q;
	logic [40:0] d0_q, d1_q, d2_q;
	logic [41:0] q_sum;
	trz_pkg::frag_t pend_q;
	logic        pend_vld_q;

	// Divider pair.
	logic                      div_start;
	logic [trz_pkg::DIV_W-1:0] div_num_a, div_num_b, div_den;
	logic                      div_done_a, div_done_b;
	logic [16:0]               quo_a, quo_b;

	trz_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_a),
		.den    (div_den),
		.done   (div_done_a),
		.quo    (quo_a)
	);

	trz_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_b),
		.den    (div_den),
		.done   (div_done_b),
		.quo    (quo_b)
	);

	// Bounding box from the registered vertices.
	logic signed [17:0] min_x, max_x, min_y, max_y;
	logic signed [14:0] fx0, fy0, cx1, cy1, lim_w, lim_h, lim_tx, lim_ty;
	logic signed [14:0] cl_x0, cl_y0, cl_x1, cl_y1;
	logic [12:0]        sw_c, sh_c;

	always_comb begin
		min_x = (vx0_q < vx1_q) ? vx0_q : vx1_q;
		min_x = (min_x < vx2_q) ? min_x : vx2_q;
		max_x = (vx0_q > vx1_q) ? vx0_q : vx1_q;
		max_x = (max_x > vx2_q) ? max_x : vx2_q;
		min_y = (vy0_q < vy1_q) ? vy0_q : vy1_q;
		min_y = (min_y < vy2_q) ? min_y : vy2_q;
		max_y = (vy0_q > vy1_q) ? vy0_q : vy1_q;
		max_y = (max_y > vy2_q) ? max_y : vy2_q;
		fx0 = 15'(min_x >>> 4);
		fy0 = 15'(min_y >>> 4);
		cx1 = 15'((19'(max_x) + 19'sd15) >>> 4);
		cy1 = 15'((19'(max_y) + 19'sd15) >>> 4);
		sw_c = (cfg.screen_w > 13'd4096) ? 13'd4096 : cfg.screen_w;
		sh_c = (cfg.screen_h > 13'd4096) ? 13'd4096 : cfg.screen_h;
		lim_w = $signed({2'b00, sw_c}) - 15'sd1;
		lim_h = $signed({2'b00, sh_c}) - 15'sd1;
		lim_tx = $signed({3'b000, cfg.origin_x}) + 15'(trz_pkg::TILE_SIZE - 1);
		lim_ty = $signed({3'b000, cfg.origin_y}) + 15'(trz_pkg::TILE_SIZE - 1);
		cl_x0 = (fx0 < 15'sd0) ? 15'sd0 : fx0;
		cl_y0 = (fy0 < 15'sd0) ? 15'sd0 : fy0;
		cl_x1 = (cx1 > lim_w) ? lim_w : cx1;
		cl_y1 = (cy1 > lim_h) ? lim_h : cy1;
		if (cl_x0 < $signed({3'b000, cfg.origin_x})) cl_x0 = $signed({3'b000, cfg.origin_x});
		if (cl_y0 < $signed({3'b000, cfg.origin_y})) cl_y0 = $signed({3'b000, cfg.origin_y});
		if (cl_x1 > lim_tx) cl_x1 = lim_tx;
		if (cl_y1 > lim_ty) cl_y1 = lim_ty;
		if (cl_x1 > 15'sd4095) cl_x1 = 15'sd4095;
		if (cl_y1 > 15'sd4095) cl_y1 = 15'sd4095;
	end

	// Edge operands of the current pixel center.
	logic signed [19:0] px, py;
	assign px = $signed({3'b000, x_q[11:0], 4'b1000});
	assign py = $signed({3'b000, y_q[11:0], 4'b1000});

	// Edge values with the winding folded in.
	logic signed [41:0] e0_r, e1_r, e0_n, e1_n, e2_n, ar_n;
	always_comb begin
		e0_r = m0_q - m1_q;
		e1_r = m2_q - m3_q;
		if (area_q < 0) begin
			e0_n = -e0_r;
			e1_n = -e1_r;
			ar_n = -area_q;
		end else begin
			e0_n = e0_r;
			e1_n = e1_r;
			ar_n = area_q;
		end
		e2_n = ar_n - e0_n - e1_n;
	end

	// Sum of the perspective terms, formed from the registered products.
	assign q_sum = {1'b0, q0_q} + {1'b0, q1_q} + {1'b0, q2_q};

	// Divider operands by phase.
	always_comb begin
		if (state_q == ST_EDGE) begin
			div_num_a = e0_n[trz_pkg::DIV_W-1:0];
			div_num_b = e1_n[trz_pkg::DIV_W-1:0];
			div_den   = ar_n[trz_pkg::DIV_W-1:0];
		end else begin
			div_num_a = {1'b0, q0_q};
			div_num_b = {1'b0, q1_q};
			div_den   = q_sum;
		end
	end
	assign div_start = ((state_q == ST_EDGE) && !e0_n[41] && !e1_n[41] && !e2_n[41]) ||
	                   ((state_q == ST_QS) && (q_sum != '0));

	// Third weights, depth, store address.
	logic [16:0] s2, p2;
	logic [42:0] dsum;
	logic [26:0] dep_w;
	logic [23:0] dep;
	logic [11:0] lx, ly;
	logic        pass, out_free, last_px;
	assign s2      = 17'd65536 - s0_q - s1_q;
	assign p2      = 17'd65536 - p0_q - p1_q;
	assign dsum    = {2'b00, d0_q} + {2'b00, d1_q} + {2'b00, d2_q};
	assign dep_w   = dsum[42:16];
	assign dep     = (dep_w > 27'(trz_pkg::FAR_DEPTH)) ? trz_pkg::FAR_DEPTH : dep_w[23:0];
	assign lx      = x_q[11:0] - cfg.origin_x;
	assign ly      = y_q[11:0] - cfg.origin_y;
	assign pass    = dep < mem_rd_data;
	assign out_free = !out_valid || out_ready;
	assign last_px = (x_q == bx1_q) && (y_q == by1_q);
	assign in_ready = (state_q == ST_IDLE);

	// Depth store requests.
	always_comb begin
		mem_req.addr    = trz_pkg::ADDR_W'(ly * 12'(trz_pkg::TILE_SIZE) + lx);
		mem_req.wr_data = dep;
		mem_req.rd_en   = (state_q == ST_QS) && (q_sum != '0);
		mem_req.wr_en   = (state_q == ST_DEP) && pass && (!pend_vld_q || out_free);
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vx0_q <= $signed(in_data[17:0]);
				vy0_q <= $signed(in_data[35:18]);
				z0_q  <= in_data[59:36];
				w0_q  <= in_data[83:60];
				vx1_q <= $signed(in_data[101:84]);
				vy1_q <= $signed(in_data[119:102]);
				z1_q  <= in_data[143:120];
				w1_q  <= in_data[167:144];
				vx2_q <= $signed(in_data[185:168]);
				vy2_q <= $signed(in_data[203:186]);
				z2_q  <= in_data[227:204];
				w2_q  <= in_data[251:228];
			end
			ST_SET1: begin
				am0_q <= 42'((19'(vx2_q) - 19'(vx0_q)) * (19'(vy1_q) - 19'(vy0_q)));
				am1_q <= 42'((19'(vy2_q) - 19'(vy0_q)) * (19'(vx1_q) - 19'(vx0_q)));
				bx0_q <= cl_x0;
				by0_q <= cl_y0;
				bx1_q <= cl_x1;
				by1_q <= cl_y1;
			end
			ST_SET2: begin
				area_q <= am0_q - am1_q;
			end
			ST_MUL: begin
				m0_q <= 42'((px - 20'(vx1_q)) * (19'(vy2_q) - 19'(vy1_q)));
				m1_q <= 42'((py - 20'(vy1_q)) * (19'(vx2_q) - 19'(vx1_q)));
				m2_q <= 42'((px - 20'(vx2_q)) * (19'(vy0_q) - 19'(vy2_q)));
				m3_q <= 42'((py - 20'(vy2_q)) * (19'(vx0_q) - 19'(vx2_q)));
			end
			ST_DIV1: begin
				s0_q <= quo_a;
				s1_q <= quo_b;
			end
			ST_Q: begin
				q0_q <= s0_q * w0_q;
				q1_q <= s1_q * w1_q;
				q2_q <= s2 * w2_q;
			end
			ST_DIV2: begin
				p0_q <= quo_a;
				p1_q <= quo_b;
			end
			ST_DMUL: begin
				d0_q <= p0_q * z0_q;
				d1_q <= p1_q * z1_q;
				d2_q <= p2 * z2_q;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DEP && pass && (!pend_vld_q || out_free)) begin
			pend_q.pixel_x    <= x_q[11:0];
			pend_q.pixel_y    <= y_q[11:0];
			pend_q.frag_depth <= dep;
			pend_q.bary_zero  <= p0_q[16] ? 16'hFFFF : p0_q[15:0];
			pend_q.bary_one   <= p1_q[16] ? 16'hFFFF : p1_q[15:0];
			pend_q.last       <= 1'b0;
		end
	end

	// Sequencer, scan position, pending fragment and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= '0;
			y_q        <= '0;
			pend_vld_q <= 1'b0;
			out_valid  <= 1'b0;
			out_frag   <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SET1;
				end
				ST_SET1: begin
					state_q <= ST_SET2;
				end
				ST_SET2: begin
					x_q <= bx0_q;
					y_q <= by0_q;
					if ((am0_q == am1_q) || (bx0_q > bx1_q) || (by0_q > by1_q)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					if (div_start) begin
						state_q <= ST_DIV1;
					end else begin
						state_q <= last_px ? ST_FIN : ST_MUL;
						if (x_q == bx1_q) begin
							x_q <= bx0_q;
							y_q <= y_q + 15'sd1;
						end else begin
							x_q <= x_q + 15'sd1;
						end
					end
				end
				ST_DIV1: begin
					if (div_done_a) state_q <= ST_Q;
				end
				ST_Q: begin
					state_q <= ST_QS;
				end
				ST_QS: begin
					if (div_start) begin
						state_q <= ST_DIV2;
					end else begin
						state_q <= last_px ? ST_FIN : ST_MUL;
						if (x_q == bx1_q) begin
							x_q <= bx0_q;
							y_q <= y_q + 15'sd1;
						end else begin
							x_q <= x_q + 15'sd1;
						end
					end
				end
				ST_DIV2: begin
					if (div_done_b) state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					state_q <= ST_DEP;
				end
				ST_DEP: begin
					if (!pass || !pend_vld_q || out_free) begin
						if (pass) begin
							pend_vld_q <= 1'b1;
							if (pend_vld_q) begin
								out_frag  <= pend_q;
								out_valid <= 1'b1;
							end
						end
						state_q <= last_px ? ST_FIN : ST_MUL;
						if (x_q == bx1_q) begin
							x_q <= bx0_q;
							y_q <= y_q + 15'sd1;
						end else begin
							x_q <= x_q + 15'sd1;
						end
					end
				end
				ST_FIN: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_frag      <= pend_q;
						out_frag.last <= 1'b1;
						out_valid     <= 1'b1;
						pend_vld_q    <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/tile_triangle_rasterizer_zbuffer_top.sv
// ----------------------------------------------------------------------------
// tile_triangle_rasterizer_zbuffer_top
// Edge-function triangle rasterizer over one tile with a depth store.
// ----------------------------------------------------------------------------
// Sequence: setup runs through SET1 and SET2 after a triangle word is taken;
// each pixel runs MUL and EDGE, one inside adds a divider pass for the screen
// weights and, unless its weight sum is zero, a perspective pass and depth test.
// Throughput: one triangle at a time; up to 64 pixels per triangle.
// A fragment is held until the next passing pixel; the last leaves at scan end.
// Reset clears the depth store to far and loads the register defaults.
`default_nettype none
module tile_triangle_rasterizer_zbuffer_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// v0_x, v0_y, v0_depth, v0_inv_w, v1_x, v1_y, v1_depth, v1_inv_w,
	// v2_x, v2_y, v2_depth, v2_inv_w
	input  wire logic [255:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pixel_x, pixel_y, frag_depth, bary_zero, bary_one
	output logic [79:0]       m_axis_tdata,
	output logic              m_axis_tlast,
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [12:0]  cfg_data
);

	trz_pkg::cfg_t     cfg_q;
	trz_pkg::mem_req_t mem_req;
	trz_pkg::frag_t    frag;
	logic [23:0]       mem_rd_data;
	logic              store_clear;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.screen_w <= 13'd640;
			cfg_q.screen_h <= 13'd480;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				trz_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data[11:0];
				trz_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data[11:0];
				trz_pkg::REG_SCREEN_W: cfg_q.screen_w <= cfg_data;
				trz_pkg::REG_SCREEN_H: cfg_q.screen_h <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Any origin write empties the depth store.
	assign store_clear = cfg_wr_en &&
		((cfg_index == trz_pkg::REG_ORIGIN_X) || (cfg_index == trz_pkg::REG_ORIGIN_Y));

	trz_depth_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (store_clear),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	trz_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata[251:0]),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_frag    (frag)
	);

	// Output word packing.
	assign m_axis_tdata = {frag.bary_one, frag.bary_zero, frag.frag_depth,
	                       frag.pixel_y, frag.pixel_x};
	assign m_axis_tlast = frag.last;

endmodule
`default_nettype wire

// File: sim/tile_triangle_rasterizer_zbuffer_top_test.sv
// ----------------------------------------------------------------------------
// tile_triangle_rasterizer_zbuffer_top_test
// Self-checking bench for the tile rasterizer with depth store. Triangles go
// in on the slave stream and fragments come out on the master stream. A
// fixed-point software rasterizer in the bench predicts every fragment,
// including the depth test against its own copy of the tile store. Several
// register settings are visited, with random idling on both streams early on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tile_triangle_rasterizer_zbuffer_top_test;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 3200;
	localparam int ITEMS_PER_PHASE = 23;
	localparam int NUM_PHASES = 7;

	typedef struct packed {
		logic [23:0]        inv_w;
		logic [23:0]        depth;
		logic signed [17:0] y;
		logic signed [17:0] x;
	} vertex_t;

	typedef vertex_t [2:0] triangle_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_wr_en;
	logic [1:0]   cfg_index;
	logic [12:0]  cfg_data;

	// Bench copy of the block's registers and tile depth store.
	logic [11:0] org_x, org_y;
	logic [12:0] scr_w, scr_h;
	logic [23:0] zstore [trz_pkg::STORE_DEPTH];

	trz_pkg::frag_t frag_q[$];
	int    errors;
	int    send_idle_pct, recv_stall_pct;
	int    quiet;

	tile_triangle_rasterizer_zbuffer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
	endfunction

	function automatic void clear_zstore();
		for (int i = 0; i < trz_pkg::STORE_DEPTH; i++) zstore[i] = trz_pkg::FAR_DEPTH;
	endfunction

	// Rasterize one triangle against the bench store and queue its fragments.
	function automatic void rasterize(input triangle_t t);
		longint vx[3], vy[3], vz[3], vw[3];
		longint area, ar, sw, sh, xa, xb, ya, yb, px, py, e0, e1, e2;
		longint unsigned s0, s1, s2, q0, q1, q2, qs, p0, p1, p2, dep;
		int idx, n;
		trz_pkg::frag_t f;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			vx[i] = t[i].x;
			vy[i] = t[i].y;
			vz[i] = t[i].depth;
			vw[i] = t[i].inv_w;
		end
		area = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
		if (area == 0) return;
		sw = (scr_w > 4096) ? 4096 : scr_w;
		sh = (scr_h > 4096) ? 4096 : scr_h;
		// Box from floor(min) to ceil(max), clamped to screen, tile and 4095.
		xa = vx[0]; xb = vx[0]; ya = vy[0]; yb = vy[0];
		for (int i = 1; i < 3; i++) begin
			if (vx[i] < xa) xa = vx[i];
			if (vx[i] > xb) xb = vx[i];
			if (vy[i] < ya) ya = vy[i];
			if (vy[i] > yb) yb = vy[i];
		end
		xa = xa >>> 4;
		ya = ya >>> 4;
		xb = -((-xb) >>> 4);
		yb = -((-yb) >>> 4);
		if (xa < 0) xa = 0;
		if (ya < 0) ya = 0;
		if (xb > sw - 1) xb = sw - 1;
		if (yb > sh - 1) yb = sh - 1;
		if (xa < org_x) xa = org_x;
		if (ya < org_y) ya = org_y;
		if (xb > longint'(org_x) + trz_pkg::TILE_SIZE - 1)
			xb = longint'(org_x) + trz_pkg::TILE_SIZE - 1;
		if (yb > longint'(org_y) + trz_pkg::TILE_SIZE - 1)
			yb = longint'(org_y) + trz_pkg::TILE_SIZE - 1;
		if (xb > 4095) xb = 4095;
		if (yb > 4095) yb = 4095;
		for (longint yy = ya; yy <= yb; yy++) begin
			for (longint xx = xa; xx <= xb; xx++) begin
				px = xx * 16 + 8;
				py = yy * 16 + 8;
				e0 = edge_fn(vx[1], vy[1], vx[2], vy[2], px, py);
				e1 = edge_fn(vx[2], vy[2], vx[0], vy[0], px, py);
				e2 = area - e0 - e1;
				ar = area;
				if (ar < 0) begin
					ar = -ar;
					e0 = -e0;
					e1 = -e1;
					e2 = -e2;
				end
				if (e0 < 0 || e1 < 0 || e2 < 0) continue;
				s0 = (longint'(e0) << 16) / ar;
				s1 = (longint'(e1) << 16) / ar;
				s2 = 65536 - s0 - s1;
				q0 = s0 * vw[0];
				q1 = s1 * vw[1];
				q2 = s2 * vw[2];
				qs = q0 + q1 + q2;
				// A zero weight sum rejects the pixel outright.
				if (qs == 0) continue;
				p0 = (q0 << 16) / qs;
				p1 = (q1 << 16) / qs;
				p2 = 65536 - p0 - p1;
				dep = (p0 * vz[0] + p1 * vz[1] + p2 * vz[2]) >> 16;
				if (dep > trz_pkg::FAR_DEPTH) dep = trz_pkg::FAR_DEPTH;
				idx = int'(((yy - org_y) * trz_pkg::TILE_SIZE + (xx - org_x))
					& (trz_pkg::STORE_DEPTH - 1));
				if (dep >= zstore[idx]) continue;
				zstore[idx] = dep[23:0];
				f.pixel_x = xx[11:0];
				f.pixel_y = yy[11:0];
				f.frag_depth = dep[23:0];
				f.bary_zero = (p0 > 65535) ? 16'hFFFF : p0[15:0];
				f.bary_one = (p1 > 65535) ? 16'hFFFF : p1[15:0];
				f.last = 1'b0;
				frag_q.push_back(f);
				n++;
			end
		end
		if (n > 0) frag_q[frag_q.size() - 1].last = 1'b1;
	endfunction

	function automatic triangle_t make_tri(longint x0, longint y0, longint x1, longint y1,
			longint x2, longint y2, longint z0, longint z1, longint z2,
			longint w0, longint w1, longint w2);
		triangle_t t;
		t[0].x = 18'(x0); t[0].y = 18'(y0); t[0].depth = 24'(z0); t[0].inv_w = 24'(w0);
		t[1].x = 18'(x1); t[1].y = 18'(y1); t[1].depth = 24'(z1); t[1].inv_w = 24'(w1);
		t[2].x = 18'(x2); t[2].y = 18'(y2); t[2].depth = 24'(z2); t[2].inv_w = 24'(w2);
		return t;
	endfunction

	// Mostly triangles around the current tile, some anywhere in the field range.
	function automatic triangle_t random_tri();
		triangle_t t;
		longint bx, by;
		bx = longint'(org_x) * 16;
		by = longint'(org_y) * 16;
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				t[i].x = 18'(bx + $urandom_range(0, 191) - 32);
				t[i].y = 18'(by + $urandom_range(0, 191) - 32);
			end else begin
				t[i].x = 18'($urandom);
				t[i].y = 18'($urandom);
			end
			t[i].depth = 24'($urandom);
			t[i].inv_w = ($urandom_range(0, 9) < 8) ? 24'($urandom_range(16'h4000, 20'h30000))
				: 24'($urandom);
		end
		return t;
	endfunction

	// Sender side: one triangle word, with random idle cycles in front.
	task automatic send_tri(input triangle_t t, input bit predict);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, t};
		do @(posedge clk); while (!s_axis_tready);
		if (predict) rasterize(t);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			trz_pkg::REG_ORIGIN_X: begin
				org_x = val[11:0];
				clear_zstore();
			end
			trz_pkg::REG_ORIGIN_Y: begin
				org_y = val[11:0];
				clear_zstore();
			end
			trz_pkg::REG_SCREEN_W: scr_w = val;
			trz_pkg::REG_SCREEN_H: scr_h = val;
			default: begin
			end
		endcase
	endtask

	// Wait for outstanding fragments, then let trailing pixel scans finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (frag_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// Receiver side: random stall, fragment check and watchdog.
	always @(posedge clk) begin
		trz_pkg::frag_t got, want;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tlast, m_axis_tdata};
				if (frag_q.size() == 0) begin
					$error("unexpected fragment x=%0d y=%0d", got.pixel_x, got.pixel_y);
					errors++;
				end else begin
					want = frag_q.pop_front();
					check_field("pixel_x", want.pixel_x, got.pixel_x);
					check_field("pixel_y", want.pixel_y, got.pixel_y);
					check_field("frag_depth", want.frag_depth, got.frag_depth);
					check_field("bary_zero", want.bary_zero, got.bary_zero);
					check_field("bary_one", want.bary_one, got.bary_one);
					check_field("last_fragment", want.last, got.last);
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
					|| cfg_wr_en)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		triangle_t directed[$];
		bit expect_none[$];
		errors = 0;
		quiet = 0;
		send_idle_pct = 34;
		recv_stall_pct = 49;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = trz_pkg::REG_ORIGIN_X;
		cfg_data = '0;
		org_x = 12'd0;
		org_y = 12'd0;
		scr_w = 13'd640;
		scr_h = 13'd480;
		clear_zstore();

		// Directed rows; a set flag means the triangle is culled outright.
		// Far depth never passes against a cleared store.
		directed.push_back(make_tri(0, 0, 256, 0, 0, 256, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'h10000, 24'h10000, 24'h10000)); expect_none.push_back(0);
		// Covers the whole tile.
		directed.push_back(make_tri(0, 0, 256, 0, 0, 256, 24'h800000, 24'h800000,
			24'h800000, 24'h10000, 24'h10000, 24'h10000)); expect_none.push_back(0);
		// Equal depth again: nothing is strictly nearer.
		directed.push_back(make_tri(0, 0, 256, 0, 0, 256, 24'h800000, 24'h800000,
			24'h800000, 24'h10000, 24'h10000, 24'h10000)); expect_none.push_back(0);
		// Opposite winding with extreme depths.
		directed.push_back(make_tri(0, 0, 0, 256, 256, 0, 0, 24'hFFFFFF, 24'h400000,
			24'h10000, 24'h20000, 24'h8000)); expect_none.push_back(0);
		// Collinear and degenerate triangles are culled.
		directed.push_back(make_tri(0, 0, 64, 64, 128, 128, 0, 0, 0, 1, 1, 1));
		expect_none.push_back(1);
		directed.push_back(make_tri(40, 40, 40, 40, 40, 40, 0, 0, 0, 1, 1, 1));
		expect_none.push_back(1);
		// Zero inverse w sum rejects every pixel.
		directed.push_back(make_tri(0, 0, 256, 0, 0, 256, 0, 0, 0, 0, 0, 0));
		expect_none.push_back(0);
		// Inverse w extremes.
		directed.push_back(make_tri(-16, -16, 200, 8, 8, 200, 24'h100, 24'h200, 24'h300,
			24'hFFFFFF, 1, 24'h10000)); expect_none.push_back(0);
		// Coordinate extremes covering the whole field.
		directed.push_back(make_tri(-131072, -131072, 131071, -131072, -131072, 131071,
			0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF)); expect_none.push_back(0);
		directed.push_back(make_tri(131071, 131071, -131072, 131071, 131071, -131072,
			0, 0, 0, 1, 1, 1)); expect_none.push_back(0);
		// Sliver that misses every pixel center.
		directed.push_back(make_tri(16, 16, 20, 16, 16, 20, 0, 0, 0, 1, 1, 1));
		expect_none.push_back(0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed.size(); i++) send_tri(directed[i], !expect_none[i]);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			if (phase >= 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (phase >= 2) begin
				send_idle_pct = 49;
				recv_stall_pct = 34;
			end
			case (phase)
				1: begin
					write_reg(trz_pkg::REG_ORIGIN_X, 13'd100);
					write_reg(trz_pkg::REG_ORIGIN_Y, 13'd50);
					write_reg(trz_pkg::REG_SCREEN_W, 13'd4096);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd4096);
				end
				2: begin
					// Zero width: the box is always empty.
					write_reg(trz_pkg::REG_SCREEN_W, 13'd0);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd1);
				end
				3: begin
					write_reg(trz_pkg::REG_ORIGIN_X, 13'd4095);
					write_reg(trz_pkg::REG_ORIGIN_Y, 13'd4095);
					write_reg(trz_pkg::REG_SCREEN_W, 13'd8191);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd8191);
				end
				4: begin
					write_reg(trz_pkg::REG_ORIGIN_X, 13'd4088);
					write_reg(trz_pkg::REG_ORIGIN_Y, 13'd4088);
					write_reg(trz_pkg::REG_SCREEN_W, 13'd4096);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd4096);
				end
				5: begin
					write_reg(trz_pkg::REG_ORIGIN_X, 13'd0);
					write_reg(trz_pkg::REG_ORIGIN_Y, 13'd0);
					write_reg(trz_pkg::REG_SCREEN_W, 13'd1);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd640);
				end
				6: begin
					// Rewriting an unchanged origin still clears the store.
					write_reg(trz_pkg::REG_ORIGIN_X, 13'd0);
					write_reg(trz_pkg::REG_ORIGIN_Y, 13'($urandom_range(0, 470)));
					write_reg(trz_pkg::REG_SCREEN_W, 13'd640);
					write_reg(trz_pkg::REG_SCREEN_H, 13'd480);
				end
				default: ;
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) send_tri(random_tri(), 1'b1);
		end

		settle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
